### design/maf_pkg.sv
// maf_pkg: widths, controller states and the command and status groups
// shared by the moving average controller, datapath and top level
// no dependencies
`default_nettype none

package maf_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 7;
  localparam int WIN_RESET  = 8;
  localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int DIV_STEPS  = SUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic cfg_we;
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### design/moving_average_filter.sv
// moving_average_filter: top level of the boxcar averaging filter
// depends on maf_pkg, maf_ctrl, maf_datapath
//
//  channel | direction | handshake          | payload
//  in_     | into      | in_valid/in_stall  | in_sample[15:0]
//  out_    | out of    | out_valid/out_stall| out_average[15:0]
//  cfg_    | into      | cfg_valid/cfg_ready| cfg_window_length[6:0]
//
// one request in flight: accept, update, 22 divide steps of the one-bit-a-step
// restoring divider, then hand-over of the quotient to the output register
// the finished average sits in an output register, so a new request is taken
// while it still waits; hand-over waits only if that register is still full
// synchronous active-low reset: window length 8, empty window, no result pending
// a window write clears fill count, ring position and running sum
`default_nettype none

module moving_average_filter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [maf_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [maf_pkg::SAMPLE_W-1:0]       out_average,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [maf_pkg::CFG_W-1:0]     cfg_window_length
);
  import maf_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t sts;

  // sequencer: takes requests and window writes only when idle
  maf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: ring, running sum, divider and result register
  maf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_window_length (cfg_window_length),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_average       (out_average)
  );

endmodule

`default_nettype wire

### design/maf_ctrl.sv
// maf_ctrl: sequencer for one request at a time (read, update, divide, hand over)
// depends on maf_pkg
`default_nettype none

module maf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire maf_pkg::status_t sts,
  output maf_pkg::cmd_t       cmd
);
  import maf_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // a pending window write goes first and holds off the request
        in_stall   = cfg_valid;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_UPDATE)
    else $error("accepted request did not move to update");

  a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && cnt_r == LAST_STEP) |=> state_r == ST_FINISH)
    else $error("divider did not finish after its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending one");

endmodule

`default_nettype wire

### design/maf_datapath.sv
// maf_datapath: sample ring, running sum, fill count, serial divider, result register
// depends on maf_pkg
`default_nettype none

module maf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire maf_pkg::cmd_t                 cmd,
  output maf_pkg::status_t                   sts,
  input  wire logic [maf_pkg::CFG_W-1:0]     cfg_window_length,
  input  wire logic [maf_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [maf_pkg::SAMPLE_W-1:0]       out_average
);
  import maf_pkg::*;

  logic [SAMPLE_W-1:0] ring [WINDOW_MAX];

  logic [CFG_W-1:0]    win_len_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    pos_cur_r;
  logic [POS_W-1:0]    pos_wrap;
  logic [FILL_W-1:0]   fill_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] old_r;
  logic [FILL_W-1:0]   n_eff;
  logic [FILL_W-1:0]   divisor;
  logic [FILL_W-1:0]   fill_nxt;
  logic [FILL_W-1:0]   pos_inc;

  logic [SUM_W-1:0]    quo_r;
  logic [FILL_W-1:0]   rem_r;
  logic [FILL_W-1:0]   div_r;
  logic [FILL_W:0]     rem_sh;
  logic [FILL_W:0]     rem_diff;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] avg_r;

  // zero acts as one, oversize saturates
  always_comb begin
    if (win_len_r == '0) begin
      n_eff = FILL_W'(1);
    end else if (int'(win_len_r) > WINDOW_MAX) begin
      n_eff = FILL_W'(WINDOW_MAX);
    end else begin
      n_eff = FILL_W'(win_len_r);
    end
  end

  assign pos_wrap = (FILL_W'(pos_r) >= n_eff) ? '0 : pos_r;
  assign pos_inc  = FILL_W'(pos_cur_r) + 1'b1;
  assign pos_nxt  = (pos_inc >= n_eff) ? '0 : POS_W'(pos_inc);

  always_comb begin
    if (fill_r < n_eff) begin
      fill_nxt = fill_r + 1'b1;
      divisor  = fill_r + 1'b1;
      sum_nxt  = sum_r + SUM_W'(sample_r);
    end else begin
      fill_nxt = fill_r;
      divisor  = n_eff;
      sum_nxt  = sum_r - SUM_W'(old_r) + SUM_W'(sample_r);
    end
  end

  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};

  // ring store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_r <= ring[pos_wrap];
    end
    if (cmd.update) begin
      ring[pos_cur_r] <= sample_r;
    end
  end

  // request capture and divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r  <= in_sample;
      pos_cur_r <= pos_wrap;
    end
    if (cmd.update) begin
      quo_r <= sum_nxt;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cmd.div_step) begin
      if (!rem_diff[FILL_W]) begin
        rem_r <= FILL_W'(rem_diff);
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= FILL_W'(rem_sh);
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      avg_r <= quo_r[SAMPLE_W-1:0];
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= CFG_W'(WIN_RESET);
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        win_len_r <= cfg_window_length;
        pos_r     <= '0;
        fill_r    <= '0;
        sum_r     <= '0;
      end else if (cmd.update) begin
        pos_r  <= pos_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_average  = avg_r;

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result valid without a load");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= WINDOW_MAX)
    else $error("fill count beyond ring depth");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cfg_we |=> (fill_r == '0 && sum_r == '0 && pos_r == '0))
    else $error("window write did not clear the window");

endmodule

`default_nettype wire
